// ===== src/clld_pkg.sv =====
// ---------------------------------------------------------------------------
// clld_pkg: shared definitions for the circular linked list deque
// Request and status codes, field widths and the default node store size.
// ---------------------------------------------------------------------------
package clld_pkg;

   // Default number of slots in the node store
   localparam int DEF_CAPACITY = 64;

   // Fixed field widths
   localparam int VALUE_W  = 32;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   // Request codes (the fourth code is unused and answers ok)
   typedef enum logic [REQ_W-1:0] {
      REQ_INS_HEAD = 2'd0,
      REQ_INS_TAIL = 2'd1,
      REQ_DELETE   = 2'd2
   } req_kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

// ===== src/circular_list_deque_with_delete.sv =====
// ---------------------------------------------------------------------------
// circular_list_deque_with_delete: bounded circular singly linked list
// Inserts signed values at head or tail, or deletes the first match found
// from the head. Nodes live in RAMs; one sequencer drives all accesses.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | tuser          | tdata
//  --------+-----------+----------------+--------------------------------
//  req_    | in        | [1:0] req_type | [31:0] value
//  rsp_    | out       | [1:0] status   | [CNT_W-1:0] entry_count, zero pad
//
//  Insert: the used-map RAM is scanned one slot per cycle for the lowest
//  free slot, then the node is written and, unless the list was empty, the
//  old tail is relinked. Delete: the link RAM is walked one node per cycle.
//  Full, empty and unused codes go straight to the result.
//  After reset a clearing pass over every slot zeroes the used map;
//  req_tready stays low until it ends. One transaction is in work at a time;
//  a finished result waits in the output register while the next request
//  is taken, and a stalled result holds the sequencer in its final state.
//
module circular_list_deque_with_delete #(
   parameter int CAPACITY = clld_pkg::DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request: tuser = req_type; tdata = value
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [clld_pkg::REQ_W-1:0] req_tuser,
   input  logic [clld_pkg::VALUE_W-1:0] req_tdata,
   // Response: tuser = status; tdata = entry_count, zero padded to bytes
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [clld_pkg::STATUS_W-1:0] rsp_tuser,
   output logic [(($clog2(CAPACITY+1)+7)/8)*8-1:0] rsp_tdata
);

   import clld_pkg::*;

   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY+1);
   localparam int RSP_DATA_W = ((CNT_W+7)/8)*8;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY-1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_INS,
      S_INS_LINK,
      S_DEL_START,
      S_WALK,
      S_DONE
   } state_type;

   // Registers and next values
   state_type         state_ff,    state_in;
   req_kind_type      kind_ff,     kind_in;
   logic [VALUE_W-1:0] value_ff,   value_in;
   logic [IDX_W-1:0]  head_ff,     head_in;
   logic [IDX_W-1:0]  tail_ff,     tail_in;
   logic [CNT_W-1:0]  size_ff,     size_in;
   logic [CNT_W-1:0]  cnt_ff,      cnt_in;
   logic [IDX_W-1:0]  cur_ff,      cur_in;
   logic [IDX_W-1:0]  prev_ff,     prev_in;
   logic [IDX_W-1:0]  scan_ff,     scan_in;
   logic [IDX_W-1:0]  pend_ff,     pend_in;
   logic              scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0]  slot_ff,     slot_in;
   logic [IDX_W-1:0]  clr_ff,      clr_in;
   status_type        status_ff,   status_in;
   logic              rsp_vld_ff,  rsp_vld_in;
   status_type        rsp_st_ff,   rsp_st_in;
   logic [CNT_W-1:0]  rsp_cnt_ff,  rsp_cnt_in;

   // RAM ports
   logic               val_we;
   logic [IDX_W-1:0]   val_wa;
   logic [VALUE_W-1:0] val_wd;
   logic [VALUE_W-1:0] val_rd;
   logic               lnk_we;
   logic [IDX_W-1:0]   lnk_wa;
   logic [IDX_W-1:0]   lnk_wd;
   logic [IDX_W-1:0]   lnk_rd;
   logic [IDX_W-1:0]   node_ra;
   logic               use_we;
   logic [IDX_W-1:0]   use_wa;
   logic [0:0]         use_wd;
   logic [0:0]         use_rd;

   // Node store: values, next links and the used map
   clld_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (node_ra),
      .rd_data (val_rd)
   );

   clld_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_wa),
      .wr_data (lnk_wd),
      .rd_addr (node_ra),
      .rd_data (lnk_rd)
   );

   clld_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used_ram (
      .clock   (clock),
      .wr_en   (use_we),
      .wr_addr (use_wa),
      .wr_data (use_wd),
      .rd_addr (scan_ff),
      .rd_data (use_rd)
   );

   // Node read address: follow the link just read while walking
   assign node_ra = (state_ff == S_WALK) ? lnk_rd : cur_ff;

   // Sequencer next-state logic
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      value_in    = value_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      size_in     = size_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      scan_vld_in = scan_vld_ff;
      slot_in     = slot_ff;
      clr_in      = clr_ff;
      status_in   = status_ff;
      rsp_vld_in  = rsp_vld_ff & ~rsp_tready;
      rsp_st_in   = rsp_st_ff;
      rsp_cnt_in  = rsp_cnt_ff;

      val_we = 1'b0;
      val_wa = slot_ff;
      val_wd = value_ff;
      lnk_we = 1'b0;
      lnk_wa = slot_ff;
      lnk_wd = head_ff;
      use_we = 1'b0;
      use_wa = slot_ff;
      use_wd = 1'b0;

      unique case (state_ff)
         // Zero the used map after reset, one slot a cycle
         S_CLEAR: begin
            use_we = 1'b1;
            use_wa = clr_ff;
            use_wd = 1'b0;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         // Take a request and sort out the trivial outcomes
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_kind_type'(req_tuser);
               value_in = req_tdata;
               case (req_tuser) inside
                  REQ_INS_HEAD, REQ_INS_TAIL: begin
                     if (size_ff == FULL_CNT) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        scan_in     = '0;
                        scan_vld_in = 1'b0;
                        state_in    = S_SCAN;
                     end
                  end
                  REQ_DELETE: begin
                     if (size_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        cur_in   = head_ff;
                        prev_in  = tail_ff;
                        cnt_in   = '0;
                        state_in = S_DEL_START;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         // Find the lowest free slot; reads are pipelined one per cycle
         S_SCAN: begin
            if (scan_ff != LAST_IDX) begin
               scan_in = scan_ff + IDX_W'(1);
            end
            pend_in     = scan_ff;
            scan_vld_in = 1'b1;
            if (scan_vld_ff && !use_rd[0]) begin
               slot_in  = pend_ff;
               state_in = S_INS;
            end
         end

         // Write the new node
         S_INS: begin
            val_we = 1'b1;
            val_wa = slot_ff;
            val_wd = value_ff;
            use_we = 1'b1;
            use_wa = slot_ff;
            use_wd = 1'b1;
            lnk_we = 1'b1;
            lnk_wa = slot_ff;
            if (size_ff == '0) begin
               lnk_wd    = slot_ff;
               head_in   = slot_ff;
               tail_in   = slot_ff;
               size_in   = size_ff + CNT_W'(1);
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               lnk_wd   = head_ff;
               state_in = S_INS_LINK;
            end
         end

         // Close the ring through the old tail
         S_INS_LINK: begin
            lnk_we = 1'b1;
            lnk_wa = tail_ff;
            lnk_wd = slot_ff;
            if (kind_ff == REQ_INS_HEAD) begin
               head_in = slot_ff;
            end else begin
               tail_in = slot_ff;
            end
            size_in   = size_ff + CNT_W'(1);
            status_in = ST_OK;
            state_in  = S_DONE;
         end

         // Head node read issued from cur_ff
         S_DEL_START: begin
            state_in = S_WALK;
         end

         // Compare one node per cycle, next read already issued
         S_WALK: begin
            if (val_rd == value_ff) begin
               use_we = 1'b1;
               use_wa = cur_ff;
               use_wd = 1'b0;
               if (size_ff == CNT_W'(1)) begin
                  size_in = '0;
               end else begin
                  lnk_we = 1'b1;
                  lnk_wa = prev_ff;
                  lnk_wd = lnk_rd;
                  if (cur_ff == head_ff) begin
                     head_in = lnk_rd;
                  end
                  if (cur_ff == tail_ff) begin
                     tail_in = prev_ff;
                  end
                  size_in = size_ff - CNT_W'(1);
               end
               status_in = ST_OK;
               state_in  = S_DONE;
            end else if (cnt_ff == size_ff - CNT_W'(1)) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               prev_in = cur_ff;
               cur_in  = lnk_rd;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end

         // Load the output register once it is free
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               rsp_st_in  = status_ff;
               rsp_cnt_in = size_ff;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         head_ff     <= '0;
         tail_ff     <= '0;
         size_ff     <= '0;
         clr_ff      <= '0;
         scan_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         size_ff     <= size_in;
         clr_ff      <= clr_in;
         scan_vld_ff <= scan_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      cnt_ff     <= cnt_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      scan_ff    <= scan_in;
      pend_ff    <= pend_in;
      slot_ff    <= slot_in;
      status_ff  <= status_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   // Ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_cnt_ff);

endmodule

// ===== src/clld_ram.sv =====
// ---------------------------------------------------------------------------
// clld_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ---------------------------------------------------------------------------
module clld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for circular_list_deque_with_delete
// Drives head and tail inserts, first-match deletes and the unused code on the
// request stream. A scoreboard keeps its own copy of the node store, predicts
// status and entry count for every accepted request and checks responses in order.
// ---------------------------------------------------------------------------
module tb;
   import clld_pkg::*;

   localparam int CAP    = DEF_CAPACITY;
   localparam int IDX_W  = $clog2(CAP);
   localparam int CNT_W  = $clog2(CAP + 1);
   localparam int RSP_W  = ((CNT_W + 7) / 8) * 8;
   localparam int N_RAND = 1500;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] count;
   } list_rsp_type;

   typedef enum int {PH_GROW, PH_SHRINK, PH_FILL, PH_DRAIN, PH_NOISE} phase_type;

   // -----------------------------------------------------------------------
   // Scoreboard: mirror of the linked list and queue of pending responses
   // -----------------------------------------------------------------------
   class list_scoreboard;
      logic signed [VALUE_W-1:0] node_value [CAP];
      logic [IDX_W-1:0]          node_link [CAP];
      bit                        slot_used [CAP];
      logic [IDX_W-1:0]          head_idx;
      logic [IDX_W-1:0]          tail_idx;
      int unsigned               list_size;
      list_rsp_type              expected_rsp [$];
      int unsigned               failures;
      int unsigned               peak_size;
      int unsigned               status_seen [4];

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         foreach (status_seen[i]) status_seen[i] = 0;
         head_idx  = '0;
         tail_idx  = '0;
         list_size = 0;
         failures  = 0;
         peak_size = 0;
      endfunction

      // New node takes the lowest free slot; tail always links to head
      function status_type insert_node(bit at_head, logic signed [VALUE_W-1:0] val);
         int slot;
         if (list_size >= CAP) return ST_FULL;
         slot = 0;
         for (int i = CAP - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
         slot_used[slot]  = 1'b1;
         node_value[slot] = val;
         if (list_size == 0) begin
            head_idx        = IDX_W'(slot);
            tail_idx        = IDX_W'(slot);
            node_link[slot] = IDX_W'(slot);
         end else begin
            node_link[slot]     = head_idx;
            node_link[tail_idx] = IDX_W'(slot);
            if (at_head) head_idx = IDX_W'(slot);
            else tail_idx = IDX_W'(slot);
         end
         list_size++;
         return ST_OK;
      endfunction

      // Walk from the head, unlink the first node holding the value
      function status_type delete_node(logic signed [VALUE_W-1:0] val);
         logic [IDX_W-1:0] cur;
         logic [IDX_W-1:0] prev;
         logic [IDX_W-1:0] nxt;
         if (list_size == 0) return ST_EMPTY;
         cur  = head_idx;
         prev = tail_idx;
         for (int n = 0; n < list_size; n++) begin
            if (node_value[cur] == val) begin
               slot_used[cur] = 1'b0;
               // only node gone: head and tail keep their old indices
               if (list_size == 1) begin
                  list_size = 0;
                  return ST_OK;
               end
               nxt             = node_link[cur];
               node_link[prev] = nxt;
               if (cur == head_idx) head_idx = nxt;
               if (cur == tail_idx) tail_idx = prev;
               list_size--;
               return ST_OK;
            end
            prev = cur;
            cur  = node_link[cur];
         end
         return ST_NOT_FOUND;
      endfunction

      // Accepted request: update the mirror and queue the expected response
      function void note_request(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] val);
         list_rsp_type item;
         case (kind)
            REQ_INS_HEAD: item.status = insert_node(1'b1, val);
            REQ_INS_TAIL: item.status = insert_node(1'b0, val);
            REQ_DELETE:   item.status = delete_node(val);
            default:      item.status = ST_OK;
         endcase
         item.count = CNT_W'(list_size);
         expected_rsp.push_back(item);
         status_seen[item.status]++;
         if (list_size > peak_size) peak_size = list_size;
      endfunction

      // Accepted response: compare with the oldest expectation
      function void check_response(logic [STATUS_W-1:0] st, logic [RSP_W-1:0] data);
         list_rsp_type exp_item;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: status %0d, entry_count %0d", st, data);
            failures++;
            return;
         end
         exp_item = expected_rsp.pop_front();
         if (st !== exp_item.status) begin
            $error("status: expected %0d, actual %0d", exp_item.status, st);
            failures++;
         end
         if (data !== RSP_W'(exp_item.count)) begin
            $error("entry_count: expected %0d, actual %0d", exp_item.count, data);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction

      // A value held by a random live node (list must not be empty)
      function logic [VALUE_W-1:0] pick_live();
         logic [IDX_W-1:0] cur;
         cur = head_idx;
         repeat ($urandom_range(list_size - 1)) cur = node_link[cur];
         return node_value[cur];
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // Signals and block instance
   // -----------------------------------------------------------------------
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tuser  = '0;   // [1:0] req_type
   logic [VALUE_W-1:0]  req_tdata  = '0;   // [31:0] value
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [STATUS_W-1:0] rsp_tuser;         // [1:0] status
   logic [RSP_W-1:0]    rsp_tdata;         // [6:0] entry_count, zero pad

   bit          steady       = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned sent         = 0;

   list_scoreboard sb = new();

   circular_list_deque_with_delete u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("[circular_list_deque_with_delete] ERROR");
      $finish;
   end

   // Response side: random back-pressure, one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
         if (hold_request) begin
            hold_left    = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 24);
         end
      end
   end

   // Offer one request and hold it until it is accepted
   task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, val);
      sent++;
      if (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stop offering until every response is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Small pool for duplicates and hits, otherwise the full range
   function automatic logic [VALUE_W-1:0] rand_value();
      if ($urandom_range(1)) return VALUE_W'($signed($urandom_range(15)) - 8);
      return $urandom();
   endfunction

   function automatic logic [REQ_W-1:0] rand_insert();
      return $urandom_range(1) ? REQ_INS_HEAD : REQ_INS_TAIL;
   endfunction

   function automatic logic [VALUE_W-1:0] delete_target();
      if (sb.list_size == 0) return rand_value();
      return sb.pick_live();
   endfunction

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      phase_type phase;
      int     len;
      bit     hold_done;
      bit     pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, extremes, unused code, head/tail/only deletes
      send_req(REQ_DELETE, 32'd0);
      send_req(2'd3, 32'h0000_0000);
      send_req(REQ_INS_HEAD, 32'h7FFF_FFFF);
      send_req(REQ_INS_TAIL, 32'h8000_0000);
      send_req(REQ_INS_HEAD, 32'h0000_0000);
      send_req(REQ_INS_TAIL, 32'hFFFF_FFFF);
      send_req(REQ_DELETE, 32'd12345);
      send_req(2'd3, 32'hFFFF_FFFF);
      send_req(REQ_DELETE, 32'h0000_0000);
      send_req(REQ_DELETE, 32'hFFFF_FFFF);
      send_req(REQ_DELETE, 32'h7FFF_FFFF);
      send_req(REQ_DELETE, 32'h8000_0000);
      send_req(REQ_DELETE, 32'h8000_0000);
      send_req(REQ_INS_TAIL, 32'd5);
      send_req(REQ_INS_TAIL, 32'd5);
      send_req(REQ_INS_HEAD, 32'd6);
      send_req(REQ_DELETE, 32'd5);
      send_req(REQ_DELETE, 32'd5);
      send_req(REQ_DELETE, 32'd6);
      send_req(REQ_INS_HEAD, 32'hAAAA_5555);
      send_req(REQ_DELETE, 32'h5555_AAAA);
      send_req(REQ_DELETE, 32'hAAAA_5555);

      // Random phases of mostly well-formed traffic
      while (sent < N_RAND) begin
         steady = (sent >= 600 && sent < 900);
         if (!hold_done && sent >= 300) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (!pause_done && sent >= 1100) begin
            wait_idle();
            pause_done = 1'b1;
         end
         phase = phase_type'($urandom_range(PH_NOISE));
         len   = $urandom_range(10, 60);
         case (phase)
            PH_FILL: begin
               while (sb.list_size < CAP) send_req(rand_insert(), rand_value());
               repeat ($urandom_range(1, 3)) send_req(rand_insert(), rand_value());
            end
            PH_DRAIN: begin
               while (sb.list_size > 0) send_req(REQ_DELETE, sb.pick_live());
               send_req(REQ_DELETE, rand_value());
            end
            PH_GROW: begin
               repeat (len)
                  if ($urandom_range(99) < 80) send_req(rand_insert(), rand_value());
                  else send_req(REQ_DELETE, delete_target());
            end
            PH_SHRINK: begin
               repeat (len) begin
                  case ($urandom_range(9))
                     0, 1:    send_req(rand_insert(), rand_value());
                     2:       send_req(REQ_DELETE, $urandom());
                     default: send_req(REQ_DELETE, delete_target());
                  endcase
               end
            end
            default: begin
               repeat (len) send_req(REQ_W'($urandom_range(3)), $urandom());
            end
         endcase
      end
      steady = 1'b0;

      // Drain and let the block settle
      wait_idle();
      repeat (2 * CAP + 8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
         sb.failures++;
      end

      $display("Requests: %0d; ok %0d, full %0d, empty %0d, not found %0d",
               sent, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
               sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOT_FOUND]);
      $display("Peak list size %0d of %0d slots", sb.peak_size, CAP);
      if (sb.failures == 0) begin
         $display("[circular_list_deque_with_delete] OK");
      end else begin
         $display("[circular_list_deque_with_delete] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/clld_pkg.sv
src/clld_ram.sv
src/circular_list_deque_with_delete.sv
tb/tb.sv
